[hw/rtl/cca_pkg.sv]
// Shared constants, register and operation codes, and request/result types
// for the cyclic 1-D cellular automaton. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

  // Row geometry
  localparam int unsigned RowCells = 1024;
  localparam int unsigned WordBits = 64;
  localparam int unsigned RowWords = RowCells / WordBits;
  localparam int unsigned IdxW     = $clog2(RowWords);
  localparam int unsigned BitW     = $clog2(WordBits);
  localparam int unsigned LenW     = $clog2(RowCells) + 1;
  localparam int unsigned GenW     = 16;

  // Widest neighbourhood reach on either side of a cell
  localparam int unsigned MaxRadius = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgRuleBits   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTotalistic = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRadius     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRowLength  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGenLimit   = 3'd4;

  // Register reset values
  localparam logic [7:0]      RuleReset   = 8'd30;
  localparam logic [1:0]      RadiusReset = 2'd1;
  localparam logic [LenW-1:0] LengthReset = LenW'(RowCells);
  localparam logic [GenW-1:0] LimitReset  = 16'd1080;

  // Request operations and result status
  localparam logic OpLoad     = 1'b0;
  localparam logic OpStep     = 1'b1;
  localparam logic StatusWord = 1'b0;
  localparam logic StatusDone = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [IdxW-1:0]     word_index;
    logic [WordBits-1:0] word_data;
  } cca_req_t;

  typedef struct packed {
    logic                status;
    logic [IdxW-1:0]     out_index;
    logic [WordBits-1:0] out_cells;
    logic                last_word;
  } cca_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/cyclic_1d_cellular_automaton.sv]
// Cyclic 1-D cellular automaton: one row of cells in a word memory, stepped in place.
// Depends on cca_pkg for constants, codes and the request/result types.
`timescale 1ns / 1ps
`default_nettype none

// One request per operation. A load writes one 64-cell seed word and gives no
// result. A step fetches three words first (the last live word, the word below it
// and word 0, which supply the wrap-around cells), then reads, updates and writes
// back one row word per cycle while the result side takes them, emitting all 16
// words in index order with the last one flagged; a result stall holds the step. The
// row memory has a single read port. A step once the generation limit is reached
// gives one done result. The row memory reads as zero after reset through per-word
// valid bits, so no clearing pass is needed. Configuration writes take effect at
// once and belong between requests.
module cyclic_1d_cellular_automaton (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [cca_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [cca_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  cca_pkg::cca_req_t           in_req_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output cca_pkg::cca_rsp_t                 out_rsp_o
);

  localparam int unsigned WordBits = cca_pkg::WordBits;
  localparam int unsigned RowWords = cca_pkg::RowWords;
  localparam int unsigned IdxW     = cca_pkg::IdxW;
  localparam int unsigned BitW     = cca_pkg::BitW;
  localparam int unsigned LenW     = cca_pkg::LenW;
  localparam int unsigned GenW     = cca_pkg::GenW;
  localparam int unsigned Ctx      = cca_pkg::MaxRadius;
  localparam int unsigned CtxIdxW  = $clog2(Ctx);
  localparam int unsigned ExtW     = WordBits + 2 * Ctx;
  localparam int unsigned OffW     = LenW + 1;
  localparam int unsigned PairW    = 2 * WordBits;
  localparam int unsigned PairIdxW = BitW + 1;
  localparam int unsigned CntW     = $clog2(2 * Ctx + 2);

  typedef enum logic [5:0] {
    StIdle     = 6'b000001,
    StPreLast  = 6'b000010,
    StPrePrev  = 6'b000100,
    StPreZero  = 6'b001000,
    StRun      = 6'b010000,
    StDone     = 6'b100000
  } cca_state_e;

  // Configuration registers
  logic [7:0]      rule_q;
  logic            total_q;
  logic [1:0]      radius_q;
  logic [LenW-1:0] length_q;
  logic [GenW-1:0] limit_q;

  // Control state
  cca_state_e      state_q, state_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [GenW-1:0] gen_q, gen_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] last_q, last_d;
  logic            out_valid_q;

  // Datapath registers
  logic [WordBits-1:0] wlast_q;
  logic [WordBits-1:0] cur_q;
  logic [Ctx-1:0]      prv3_q;
  logic [Ctx-1:0]      wrap3_q;
  cca_pkg::cca_rsp_t   out_rsp_q, out_d;

  // Row memory
  logic [WordBits-1:0] row_mem_q [RowWords];
  logic [RowWords-1:0] row_vld_q;
  logic [WordBits-1:0] rdata_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_addr;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [WordBits-1:0] mem_wdata;
  logic [WordBits-1:0] rd_word;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [LenW-1:0]     len_eff;
  logic [IdxW-1:0]     last_cfg;
  logic [LenW-1:0]     len_m1;

  // Word update
  logic [LenW-1:0]     diff;
  logic [ExtW-1:0]     raw;
  logic [ExtW-1:0]     ext;
  logic [OffW-1:0]     e_off;
  logic [CntW-1:0]     cnt;
  logic [2:0]          code;
  logic [2:0]          sel;
  logic [WordBits-1:0] next_word;

  // Wrap-around cells
  logic [PairW-1:0]    pair;
  logic [PairIdxW-1:0] tidx;
  logic [LenW-1:0]     lm1;
  logic [Ctx-1:0]      wrap_new;
  logic [Ctx-1:0]      tail_new;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign rd_word     = rd_vld_q ? rdata_q : '0;

  // Effective row length: zero acts as one, anything too long is clipped
  always_comb begin
    if (length_q == '0) begin
      len_eff = LenW'(1);
    end else if (length_q > LenW'(cca_pkg::RowCells)) begin
      len_eff = LenW'(cca_pkg::RowCells);
    end else begin
      len_eff = length_q;
    end
  end

  assign len_m1   = len_eff - LenW'(1);
  assign last_cfg = IdxW'(len_m1 >> BitW);

  // Cells just below cell 0 and just past the last cell, for short rows repeated
  assign lm1  = len_q - LenW'(1);
  assign pair = {wlast_q, rd_word};
  assign tidx = {1'b1, lm1[BitW-1:0]} - PairIdxW'(Ctx - 1);

  always_comb begin
    if (len_q == LenW'(1)) begin
      wrap_new = {Ctx{rd_word[0]}};
      tail_new = {Ctx{wlast_q[0]}};
    end else if (len_q == LenW'(2)) begin
      wrap_new = {rd_word[0], rd_word[1], rd_word[0]};
      tail_new = {wlast_q[1], wlast_q[0], wlast_q[1]};
    end else begin
      wrap_new = rd_word[Ctx-1:0];
      tail_new = pair[tidx +: Ctx];
    end
  end

  // New cells of word k: old word k, with context cells on both sides and the wrap
  // cells spliced in from the row end onwards
  assign diff = len_q - LenW'({k_q, {BitW{1'b0}}});
  assign raw  = {rd_word[Ctx-1:0], cur_q, prv3_q};

  always_comb begin
    ext = '0;
    for (int t = 0; t < ExtW; t++) begin
      e_off = OffW'(t) - {1'b0, diff} - OffW'(Ctx);
      if (e_off[OffW-1]) begin
        ext[t] = raw[t];
      end else if (e_off < OffW'(Ctx)) begin
        ext[t] = wrap3_q[e_off[CtxIdxW-1:0]];
      end else begin
        ext[t] = 1'b0;
      end
    end
  end

  always_comb begin
    next_word = '0;
    for (int j = 0; j < WordBits; j++) begin
      code = {ext[j+Ctx+1], ext[j+Ctx], ext[j+Ctx-1]};
      cnt  = '0;
      for (int d = 0; d < 2 * Ctx + 1; d++) begin
        if ((d + int'(radius_q) >= Ctx) && (d <= Ctx + int'(radius_q))) begin
          cnt = cnt + CntW'(ext[j+d]);
        end
      end
      sel = total_q ? cnt[2:0] : code;
      next_word[j] = rule_q[sel] & (LenW'(j) < diff);
    end
    // words wholly past the row end stay clear
    if (k_q > last_q) begin
      next_word = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    gen_d     = gen_q;
    len_d     = len_q;
    last_d    = last_q;
    rd_addr   = k_q + IdxW'(1);
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = next_word;
    out_load  = 1'b0;
    out_d     = out_rsp_q;

    unique case (state_q)
      StIdle: begin
        rd_addr = last_cfg;
        if (in_acc) begin
          if (in_req_i.operation == cca_pkg::OpLoad) begin
            mem_we    = 1'b1;
            mem_waddr = in_req_i.word_index;
            mem_wdata = in_req_i.word_data;
          end else if (gen_q >= limit_q) begin
            state_d = StDone;
          end else begin
            len_d   = len_eff;
            last_d  = last_cfg;
            state_d = StPreLast;
          end
        end
      end
      StPreLast: begin
        rd_addr = last_q - IdxW'(1);
        state_d = StPrePrev;
      end
      StPrePrev: begin
        rd_addr = '0;
        state_d = StPreZero;
      end
      StPreZero: begin
        rd_addr = IdxW'(1);
        k_d     = '0;
        state_d = StRun;
      end
      StRun: begin
        // on a stall re-read word k+1 so the read data holds
        if (out_free) begin
          out_load        = 1'b1;
          out_d.status    = cca_pkg::StatusWord;
          out_d.out_index = k_q;
          out_d.out_cells = next_word;
          out_d.last_word = (k_q == IdxW'(RowWords - 1));
          mem_we          = 1'b1;
          rd_addr         = k_q + IdxW'(2);
          k_d             = k_q + IdxW'(1);
          if (k_q == IdxW'(RowWords - 1)) begin
            gen_d   = gen_q + GenW'(1);
            state_d = StIdle;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.status    = cca_pkg::StatusDone;
          out_d.out_index = '0;
          out_d.out_cells = '0;
          out_d.last_word = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      gen_q       <= '0;
      len_q       <= cca_pkg::LengthReset;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      rule_q      <= cca_pkg::RuleReset;
      total_q     <= 1'b0;
      radius_q    <= cca_pkg::RadiusReset;
      length_q    <= cca_pkg::LengthReset;
      limit_q     <= cca_pkg::LimitReset;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      gen_q   <= gen_d;
      len_q   <= len_d;
      last_q  <= last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[rd_addr];
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cca_pkg::CfgRuleBits:   rule_q   <= cfg_data_i[7:0];
          cca_pkg::CfgTotalistic: total_q  <= cfg_data_i[0];
          cca_pkg::CfgRadius:     radius_q <= cfg_data_i[1:0];
          cca_pkg::CfgRowLength:  length_q <= cfg_data_i[LenW-1:0];
          cca_pkg::CfgGenLimit:   limit_q  <= cfg_data_i[GenW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= row_mem_q[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StPreLast) begin
      wlast_q <= rd_word;
    end
    if (state_q == StPrePrev) begin
      prv3_q <= tail_new;
    end
    if (state_q == StPreZero) begin
      cur_q   <= rd_word;
      wrap3_q <= wrap_new;
    end
    if ((state_q == StRun) && out_free) begin
      // advance the window by one word
      prv3_q <= cur_q[WordBits-1 -: Ctx];
      cur_q  <= rd_word;
    end
    if (out_load) begin
      out_rsp_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for cyclic_1d_cellular_automaton: directed and random
// requests with a bit-level row predictor. Depends on cca_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import cca_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  cca_req_t            in_req      = '0;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  cca_rsp_t            out_rsp_o;

  cyclic_1d_cellular_automaton i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  localparam int unsigned CellW = $clog2(RowCells);

  // Predicted row and register copies
  bit [RowCells-1:0] row_q;
  logic [7:0]        rule_q      = RuleReset;
  logic              totalistic_q = 1'b0;
  logic [1:0]        radius_q    = RadiusReset;
  logic [10:0]       length_q    = 11'(RowCells);
  logic [GenW-1:0]   limit_q     = LimitReset;
  logic [GenW-1:0]   gen_count_q = '0;

  cca_req_t    pending_reqs[$];
  cca_rsp_t    expected_words[$];
  cca_rsp_t    want;
  int unsigned mismatch_count = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned rx_mode    = 0;
  int unsigned mode_left  = 0;
  int unsigned hold_cnt   = 0;
  int unsigned rx_results = 0;
  int unsigned next_hold_at = 300;

  // Apply one request to the predicted row and queue the words it gives.
  task automatic advance_row(input cca_req_t req);
    bit [RowCells-1:0] next_row;
    int unsigned       len, cnt, sel, i, d, p;
    cca_rsp_t          rsp;
    if (req.operation == OpLoad) begin
      row_q[{req.word_index, {BitW{1'b0}}} +: WordBits] = req.word_data;
      return;
    end
    if (gen_count_q >= limit_q) begin
      rsp.status    = StatusDone;
      rsp.out_index = '0;
      rsp.out_cells = '0;
      rsp.last_word = 1'b1;
      expected_words.push_back(rsp);
      return;
    end
    len = (length_q == 11'd0) ? 1 : (32'(length_q) > RowCells) ? RowCells : 32'(length_q);
    next_row = '0;
    for (i = 0; i < len; i++) begin
      if (totalistic_q) begin
        cnt = 0;
        // wrap both ways; a short row may count a cell more than once
        for (d = 0; d <= 2 * 32'(radius_q); d++) begin
          p = (i + len * 4 + d - 32'(radius_q)) % len;
          cnt += 32'(row_q[CellW'(p)]);
        end
        sel = cnt;
      end else begin
        sel = 32'({row_q[CellW'((i + 1) % len)], row_q[CellW'(i)],
                   row_q[CellW'((i + len - 1) % len)]});
      end
      next_row[CellW'(i)] = rule_q[3'(sel)];
    end
    row_q = next_row;
    gen_count_q = gen_count_q + 16'd1;
    for (i = 0; i < RowWords; i++) begin
      rsp.status    = StatusWord;
      rsp.out_index = IdxW'(i);
      rsp.out_cells = next_row[CellW'(i * WordBits) +: WordBits];
      rsp.last_word = (i == RowWords - 1);
      expected_words.push_back(rsp);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CfgRuleBits:   rule_q       = data[7:0];
      CfgTotalistic: totalistic_q = data[0];
      CfgRadius:     radius_q     = data[1:0];
      CfgRowLength:  length_q     = data[10:0];
      CfgGenLimit:   limit_q      = data[GenW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WordBits-1:0] random_cells();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, WordBits - 1);
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_load(input int unsigned idx, input logic [WordBits-1:0] data);
    cca_req_t req;
    req.operation  = OpLoad;
    req.word_index = IdxW'(idx);
    req.word_data  = data;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_step();
    cca_req_t req;
    req.operation  = OpStep;
    req.word_index = IdxW'($urandom_range(0, RowWords - 1));
    req.word_data  = {$urandom, $urandom};
    pending_reqs.push_back(req);
  endtask

  // Hold until every request is in and every word has come, then let the block settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Request driver: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid && !in_ready_o)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid <= 1'b1;
        in_req   <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern of its own, plus a few long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) rx_results++;
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 200);
        rx_mode   = $urandom_range(0, 2);
      end else begin
        mode_left--;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (rx_results >= next_hold_at) begin
        hold_cnt = 400;
        next_hold_at += 1500;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check results first, then predict from any request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result with no request outstanding: out_index %0d", out_rsp_o.out_index);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            mismatch_count++;
          end
          if (out_rsp_o.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, out_rsp_o.out_index);
            mismatch_count++;
          end
          if (out_rsp_o.out_cells !== want.out_cells) begin
            $error("out_cells: expected %h, got %h", want.out_cells, out_rsp_o.out_cells);
            mismatch_count++;
          end
          if (out_rsp_o.last_word !== want.last_word) begin
            $error("last_word: expected %0d, got %0d", want.last_word, out_rsp_o.last_word);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready_o) advance_row(in_req);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL cyclic_1d_cellular_automaton");
    $finish;
  end

  initial begin
    int unsigned ph, n, nl, ns, k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: rule 30, elementary, full row
    queue_step();
    queue_load(0, 64'h1);
    // top cell of the row is the left neighbour of cell 0
    queue_load(RowWords - 1, 64'h8000_0000_0000_0000);
    queue_step();
    queue_step();
    queue_load(7, '1);
    queue_load(8, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_step();
    wait_drained();

    // Totalistic, widest window on a five-cell row
    write_reg(CfgTotalistic, 16'd1);
    write_reg(CfgRadius, 16'd3);
    write_reg(CfgRuleBits, 16'h96);
    write_reg(CfgRowLength, 16'd5);
    queue_load(0, 64'hFFFF_FFFF_FFFF_FFF5);
    queue_step();
    queue_step();
    wait_drained();

    // Zero length acts as a single cell
    write_reg(CfgRadius, 16'd0);
    write_reg(CfgRowLength, 16'd0);
    queue_load(0, 64'h1);
    queue_step();
    queue_step();
    wait_drained();

    // Oversized length acts as the full row
    write_reg(CfgTotalistic, 16'd0);
    write_reg(CfgRuleBits, 16'hFF);
    write_reg(CfgRowLength, 16'd2047);
    queue_step();
    wait_drained();

    // Generation limit: one more step, then done; a load leaves the count alone
    write_reg(CfgGenLimit, gen_count_q + 16'd1);
    queue_step();
    queue_step();
    queue_load(3, 64'h0123_4567_89AB_CDEF);
    queue_step();
    wait_drained();
    write_reg(CfgGenLimit, 16'd0);
    queue_step();
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      if (ph != 0) wait_drained();
      write_reg(CfgRuleBits,
                16'((ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(0, 255)));
      write_reg(CfgTotalistic, 16'(ph[0]));
      write_reg(CfgRadius, 16'($urandom_range(0, 3)));
      case ($urandom_range(0, 7))
        0:       write_reg(CfgRowLength, 16'd1);
        1:       write_reg(CfgRowLength, 16'd0);
        2:       write_reg(CfgRowLength, 16'($urandom_range(2, 8)));
        3:       write_reg(CfgRowLength, 16'd64);
        4:       write_reg(CfgRowLength, 16'd65);
        5:       write_reg(CfgRowLength, 16'(RowCells));
        6:       write_reg(CfgRowLength, 16'($urandom_range(RowCells + 1, 2047)));
        default: write_reg(CfgRowLength, 16'($urandom_range(1, RowCells)));
      endcase
      // one phase runs into the limit part way through
      if (ph == 3) write_reg(CfgGenLimit, gen_count_q + 16'd8);
      else         write_reg(CfgGenLimit, $urandom_range(0, 1) ? 16'hFFFF : 16'd60000);
      n = 0;
      while (n < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: lone request of either kind
          if ($urandom_range(0, 1)) queue_step();
          else queue_load($urandom_range(0, RowWords - 1), {$urandom, $urandom});
          n++;
        end else begin
          nl = $urandom_range(0, 4);
          ns = $urandom_range(1, 3);
          for (k = 0; k < nl; k++) queue_load($urandom_range(0, RowWords - 1), random_cells());
          for (k = 0; k < ns; k++) queue_step();
          n += nl + ns;
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected results never arrived", expected_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS cyclic_1d_cellular_automaton");
    end else begin
      $display("FAIL cyclic_1d_cellular_automaton");
    end
    $finish;
  end

endmodule
